FILE: sv/abcp_pkg.sv
// Shared types and constants of the aligned band chart packer.
// No dependencies; the interfaces and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package abcp_pkg;

  localparam int WIDTH_W  = 15;  // chart_width, page_width, page_pitch
  localparam int LIMIT_W  = 9;   // page_limit
  localparam int GUTTER_W = 8;
  localparam int BASE_X_W = 14;
  localparam int BASE_Y_W = 23;
  localparam int PAGE_W   = 8;   // the page number never passes 255
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] MAX_PAGES = 9'd256;

  localparam logic [WIDTH_W-1:0]  RST_PAGE_WIDTH = 15'd4096;
  localparam logic [LIMIT_W-1:0]  RST_PAGE_LIMIT = 9'd1;
  localparam logic [WIDTH_W-1:0]  RST_PAGE_PITCH = 15'd256;
  localparam logic [GUTTER_W-1:0] RST_GUTTER     = 8'd0;

  typedef enum logic [1:0] {
    REG_PAGE_WIDTH = 2'd0,
    REG_PAGE_LIMIT = 2'd1,
    REG_PAGE_PITCH = 2'd2,
    REG_GUTTER     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PLACE,
    S_OUT
  } state_t;

  localparam logic STATUS_PLACED = 1'b0;
  localparam logic STATUS_FAILED = 1'b1;

endpackage

`default_nettype wire

FILE: sv/abcp_if.sv
// Valid/ready channels of the packer: chart words in, placement words out.
// Depends on abcp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface abcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [abcp_pkg::WIDTH_W-1:0] chart_width;
  logic                        start_batch;

  modport source (output valid, output chart_width, output start_batch, input ready);
  modport sink (input valid, input chart_width, input start_batch, output ready);
endinterface

interface abcp_out_if;
  logic                          valid;
  logic                          ready;
  logic [abcp_pkg::BASE_X_W-1:0] base_x;
  logic [abcp_pkg::BASE_Y_W-1:0] base_y;
  logic [abcp_pkg::PAGE_W-1:0]   page_index;
  logic                          status;

  modport source (output valid, output base_x, output base_y, output page_index,
                  output status, input ready);
  modport sink (input valid, input base_x, input base_y, input page_index,
                input status, output ready);
endinterface

`default_nettype wire

FILE: sv/aligned_band_chart_packer.sv
// Aligned band chart packer: one-row shelf allocator over successive pages.
// Depends on abcp_pkg and the channel interfaces in abcp_if.sv.
//
// Usage: chart words enter on chart_in (valid/ready), one placement word per
// chart leaves on place_out. The APB port holds page_width, page_limit,
// page_pitch and gutter_texels; write them only while the block is idle.
// A chart whose cursor is nonzero is aligned by a serial restoring divider
// that yields one remainder bit a cycle, max(COORD_BITS, 15) + 2 steps
// (17 at COORD_BITS = 14), then passes the placement step and the output
// state. A chart on a zero cursor skips the divider; a failing chart skips
// both the divider and the placement step.
// The block holds ready low while a chart is in work. The output word sits
// in a register, so a new chart is accepted while the previous word waits;
// a stalled receiver holds the finished word and the block waits for it
// before loading the next one. Reset clears the cursor, page, failure flag
// and output valid, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module aligned_band_chart_packer #(
  parameter int COORD_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  abcp_in_if.sink                            chart_in,
  abcp_out_if.source                         place_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [abcp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [abcp_pkg::APB_DW-1:0]   pwdata,
  output logic      [abcp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int WW = abcp_pkg::WIDTH_W;
  // Dividend width: cursor + gutter + width - 1 stays below twice the capped limit plus 256.
  localparam int VW = ((COORD_BITS > WW) ? COORD_BITS : WW) + 2;
  localparam int CNT_W = $clog2(VW);
  localparam logic [VW-1:0] LIMIT_CAP = VW'(64'd1 << COORD_BITS);
  localparam int XMASK_I = (1 << COORD_BITS) - 1;
  localparam logic [abcp_pkg::BASE_X_W-1:0] X_MASK = abcp_pkg::BASE_X_W'(XMASK_I);

  // Configuration registers.
  logic [WW-1:0]                     page_width;
  logic [abcp_pkg::LIMIT_W-1:0]      page_limit;
  logic [WW-1:0]                     page_pitch;
  logic [abcp_pkg::GUTTER_W-1:0]     gutter_texels;
  abcp_pkg::reg_idx_t                reg_sel;
  logic                              cfg_write;

  // Packing state and working registers.
  abcp_pkg::state_t                  state, state_next;
  logic [WW-1:0]                     cursor;
  logic [abcp_pkg::PAGE_W-1:0]       page;
  logic                              failed;
  logic [WW-1:0]                     width;
  logic [VW-1:0]                     dividend;
  logic [VW-1:0]                     shifter;
  logic [WW-1:0]                     rem;
  logic [CNT_W-1:0]                  cnt;
  logic [VW-1:0]                     placed;
  logic                              res_fail;

  // Output register.
  logic                              out_valid;
  logic [abcp_pkg::BASE_X_W-1:0]     out_x;
  logic [abcp_pkg::BASE_Y_W-1:0]     out_y;
  logic [abcp_pkg::PAGE_W-1:0]       out_page;
  logic                              out_status;

  logic                              in_ready;
  logic                              in_accept;
  logic                              out_free;
  logic                              div_last;

  logic [VW-1:0]                     limit_w;
  logic [abcp_pkg::LIMIT_W-1:0]      limit_p;
  logic [WW-1:0]                     cur_e;
  logic [abcp_pkg::PAGE_W-1:0]       page_e;
  logic                              failed_e;
  logic                              too_wide;
  logic [WW:0]                       rem_trial;
  logic [VW-1:0]                     placed_c;
  logic [VW:0]                       end_x;
  logic                              overflow;
  logic                              out_of_pages;
  logic [abcp_pkg::LIMIT_W-1:0]      page_inc;

  // APB slave.
  assign pready    = 1'b1;
  assign reg_sel   = abcp_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width    <= abcp_pkg::RST_PAGE_WIDTH;
      page_limit    <= abcp_pkg::RST_PAGE_LIMIT;
      page_pitch    <= abcp_pkg::RST_PAGE_PITCH;
      gutter_texels <= abcp_pkg::RST_GUTTER;
    end else if (cfg_write) begin
      case (reg_sel)
        abcp_pkg::REG_PAGE_WIDTH: page_width    <= pwdata[WW-1:0];
        abcp_pkg::REG_PAGE_LIMIT: page_limit    <= pwdata[abcp_pkg::LIMIT_W-1:0];
        abcp_pkg::REG_PAGE_PITCH: page_pitch    <= pwdata[WW-1:0];
        abcp_pkg::REG_GUTTER:     gutter_texels <= pwdata[abcp_pkg::GUTTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      abcp_pkg::REG_PAGE_WIDTH: prdata = abcp_pkg::APB_DW'(page_width);
      abcp_pkg::REG_PAGE_LIMIT: prdata = abcp_pkg::APB_DW'(page_limit);
      abcp_pkg::REG_PAGE_PITCH: prdata = abcp_pkg::APB_DW'(page_pitch);
      abcp_pkg::REG_GUTTER:     prdata = abcp_pkg::APB_DW'(gutter_texels);
      default:                  prdata = '0;
    endcase
  end

  // Effective limits.
  assign limit_w = (VW'(page_width) > LIMIT_CAP) ? LIMIT_CAP : VW'(page_width);
  assign limit_p = (page_limit > abcp_pkg::MAX_PAGES) ? abcp_pkg::MAX_PAGES : page_limit;

  // A new batch clears the state before the chart is judged.
  assign cur_e    = chart_in.start_batch ? '0 : cursor;
  assign page_e   = chart_in.start_batch ? '0 : page;
  assign failed_e = chart_in.start_batch ? 1'b0 : failed;
  assign too_wide = (chart_in.chart_width == '0) ||
                    (VW'(chart_in.chart_width) > limit_w);

  // One restoring step of the remainder.
  assign rem_trial = {rem, shifter[VW-1]};
  assign div_last  = (cnt == CNT_W'(VW - 1));

  // Rounded position is the dividend minus its remainder.
  assign placed_c     = dividend - VW'(rem);
  assign end_x        = {1'b0, placed_c} + (VW + 1)'(width);
  assign overflow     = end_x > (VW + 1)'(limit_w);
  assign page_inc     = abcp_pkg::LIMIT_W'(page) + abcp_pkg::LIMIT_W'(1);
  assign out_of_pages = page_inc >= limit_p;

  assign out_free  = !out_valid || place_out.ready;
  assign in_accept = chart_in.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abcp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      abcp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (chart_in.valid) begin
          if (failed_e || too_wide) begin
            state_next = abcp_pkg::S_OUT;
          end else if (cur_e == '0) begin
            state_next = abcp_pkg::S_PLACE;
          end else begin
            state_next = abcp_pkg::S_DIV;
          end
        end
      end
      abcp_pkg::S_DIV: begin
        if (div_last) state_next = abcp_pkg::S_PLACE;
      end
      abcp_pkg::S_PLACE: begin
        state_next = abcp_pkg::S_OUT;
      end
      abcp_pkg::S_OUT: begin
        if (out_free) state_next = abcp_pkg::S_IDLE;
      end
      default: state_next = abcp_pkg::S_IDLE;
    endcase
  end

  // Packing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      page   <= '0;
      failed <= 1'b0;
    end else if (in_accept) begin
      cursor <= cur_e;
      page   <= page_e;
      failed <= failed_e || too_wide;
    end else if (state == abcp_pkg::S_PLACE) begin
      if (!overflow) begin
        cursor <= end_x[WW-1:0];
      end else if (out_of_pages) begin
        failed <= 1'b1;
      end else begin
        page   <= page_inc[abcp_pkg::PAGE_W-1:0];
        cursor <= width;
      end
    end
  end

  // Working registers of the divider and placement step.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      width    <= chart_in.chart_width;
      res_fail <= failed_e || too_wide;
      rem      <= '0;
      cnt      <= '0;
      if (cur_e == '0) begin
        dividend <= '0;
        shifter  <= '0;
      end else begin
        dividend <= VW'(cur_e) + VW'(gutter_texels) + VW'(chart_in.chart_width) - VW'(1);
        shifter  <= VW'(cur_e) + VW'(gutter_texels) + VW'(chart_in.chart_width) - VW'(1);
      end
    end else if (state == abcp_pkg::S_DIV) begin
      shifter <= {shifter[VW-2:0], 1'b0};
      cnt     <= cnt + CNT_W'(1);
      if (rem_trial >= {1'b0, width}) begin
        rem <= WW'(rem_trial - {1'b0, width});
      end else begin
        rem <= rem_trial[WW-1:0];
      end
    end else if (state == abcp_pkg::S_PLACE) begin
      if (overflow) begin
        placed   <= '0;
        res_fail <= out_of_pages;
      end else begin
        placed   <= placed_c;
      end
    end
  end

  // Output register; the page offset multiply is done on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == abcp_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (place_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == abcp_pkg::S_OUT && out_free) begin
      if (res_fail) begin
        out_x      <= '0;
        out_y      <= '0;
        out_page   <= '0;
        out_status <= abcp_pkg::STATUS_FAILED;
      end else begin
        out_x      <= placed[abcp_pkg::BASE_X_W-1:0] & X_MASK;
        out_y      <= abcp_pkg::BASE_Y_W'(page) * abcp_pkg::BASE_Y_W'(page_pitch);
        out_page   <= page;
        out_status <= abcp_pkg::STATUS_PLACED;
      end
    end
  end

  assign chart_in.ready       = in_ready;
  assign place_out.valid      = out_valid;
  assign place_out.base_x     = out_x;
  assign place_out.base_y     = out_y;
  assign place_out.page_index = out_page;
  assign place_out.status     = out_status;

`ifndef ASSERT_OFF
  // A failure word carries no position.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (place_out.valid && place_out.status == abcp_pkg::STATUS_FAILED) |->
      (place_out.base_x == '0 && place_out.base_y == '0 && place_out.page_index == '0))
    else $error("failure word with nonzero position");

  // The block is busy in the cycle after it takes a chart.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !chart_in.ready)
    else $error("chart accepted back to back");

  // After the last divider step the remainder is below the chart width.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == abcp_pkg::S_PLACE) |-> (rem < width || width == '0))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
